>>> design/lzwe_pkg.sv
`timescale 1ns / 1ps

package lzwe_pkg;

    localparam int DICT_SIZE   = 4096;
    localparam int CODE_SPACE  = 4096;
    localparam int CODE_BITS   = 12;
    localparam int FREE_BITS   = CODE_BITS + 1;
    localparam int BYTE_BITS   = 8;
    localparam int HASH_BITS   = 13;
    localparam int HASH_DEPTH  = 1 << HASH_BITS;

    // first dictionary code, and the code at which the table freezes
    localparam logic [FREE_BITS-1:0] FIRST_CODE = FREE_BITS'(256);
    localparam logic [FREE_BITS-1:0] CODE_LIMIT =
        FREE_BITS'((DICT_SIZE < CODE_SPACE) ? DICT_SIZE : CODE_SPACE);

    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [HASH_BITS-1:0] t_slot;

    // dictionary entry: pair plus the hash slot that points at it
    typedef struct packed {
        t_code                 prefix;
        logic [BYTE_BITS-1:0]  data;
        t_slot                 slot;
    } t_dict_entry;

    typedef struct packed {
        logic         en;
        t_code        addr;
        t_dict_entry  data;
    } t_dict_wr;

    typedef struct packed {
        logic   en;
        t_slot  addr;
        t_code  data;
    } t_slot_wr;

    function automatic t_slot pair_hash(input t_code prefix, input logic [BYTE_BITS-1:0] data);
        t_slot h;
        h = {prefix, 1'b0} ^ {data, 5'b0} ^ {8'b0, prefix[11:7]};
        return h;
    endfunction

endpackage

>>> design/lzwe_hash_mem.sv
`timescale 1ns / 1ps

// Hash table: slot -> dictionary code, one write and one registered read.
module lzwe_hash_mem (
    input  logic              i_clk,
    input  lzwe_pkg::t_slot_wr i_wr,
    input  lzwe_pkg::t_slot   i_rd_addr,
    output lzwe_pkg::t_code   o_rd_data
);

    lzwe_pkg::t_code r_mem [lzwe_pkg::HASH_DEPTH];
    lzwe_pkg::t_code r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/lzwe_dict_mem.sv
`timescale 1ns / 1ps

// Dictionary: code -> (prefix, byte, owning slot), one write and one registered read.
module lzwe_dict_mem (
    input  logic                   i_clk,
    input  lzwe_pkg::t_dict_wr     i_wr,
    input  lzwe_pkg::t_code        i_rd_addr,
    output lzwe_pkg::t_dict_entry  o_rd_data
);

    lzwe_pkg::t_dict_entry r_mem [lzwe_pkg::CODE_SPACE];
    lzwe_pkg::t_dict_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/lzw_encoder_unit.sv
`timescale 1ns / 1ps

// LZW encoder with a 12-bit code space. One byte is taken per input item; codes come out
// on the output channel, the final code of a stream flagged by o_last_code, after which
// the dictionary starts empty again. Pairs (prefix, byte) are found through a linearly
// probed hash table of 8192 slots that holds codes, backed by a 4096-entry dictionary
// memory; both are synchronous RAMs with a registered read. After reset the hash table is
// zeroed in a clearing pass over all 8192 slots with o_ready low; code 0 never names a
// dictionary entry, so a cleared slot reads as empty. The first byte of a stream becomes
// the prefix. Any other byte whose first probe decides passes through accept, hash slot
// read and dictionary read; each further probe repeats both reads, and each emitted code
// adds an emit state plus any wait on i_ready. Each probe makes two serial memory reads;
// with at most 3840 of the 8192 slots in use, probe chains stay short. No clearing is
// needed at end of stream: a slot counts only if its code is below the next free code and
// the dictionary entry at that code names the same slot back, so stale slots read as empty.
// The table freezes once the next free code reaches the smaller of DICT_SIZE and 4096.
module lzw_encoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lzwe_pkg::BYTE_BITS-1:0] i_data_byte,
    input  logic                        i_end_of_stream,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lzwe_pkg::CODE_BITS-1:0] o_code_word,
    output logic                        o_last_code
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_PROBE     = 3'd1;  // slot data back, read dictionary
    localparam logic [2:0] S_CHECK     = 3'd2;  // dictionary data back, decide
    localparam logic [2:0] S_EMIT_MISS = 3'd3;  // emit the missed prefix
    localparam logic [2:0] S_EMIT_LAST = 3'd4;  // emit the final prefix
    localparam logic [2:0] S_CLEAR     = 3'd5;  // zero the hash table after reset

    logic [2:0]                         r_state, n_state;
    lzwe_pkg::t_code                    r_prefix, n_prefix;
    logic                               r_prefix_valid, n_prefix_valid;
    logic [lzwe_pkg::FREE_BITS-1:0]     r_next_free, n_next_free;
    logic [lzwe_pkg::BYTE_BITS-1:0]     r_byte, n_byte;
    logic                               r_eos, n_eos;
    lzwe_pkg::t_slot                    r_slot, n_slot;
    lzwe_pkg::t_code                    r_code, n_code;
    logic                               r_cand, n_cand;
    lzwe_pkg::t_slot                    r_clear_addr, n_clear_addr;

    logic                               r_out_valid, n_out_valid;
    lzwe_pkg::t_code                    r_out_code, n_out_code;
    logic                               r_out_last, n_out_last;

    lzwe_pkg::t_slot_wr                 w_slot_wr;
    lzwe_pkg::t_dict_wr                 w_dict_wr;
    lzwe_pkg::t_slot                    w_slot_rd_addr;
    lzwe_pkg::t_code                    w_slot_q;
    lzwe_pkg::t_code                    w_dict_rd_addr;
    lzwe_pkg::t_dict_entry              w_dict_q;

    logic w_accept;
    logic w_out_free;
    logic w_entry_live;
    logic w_key_match;
    logic w_insert;
    logic w_clearing;

    lzwe_hash_mem u_hash_mem (
        .i_clk     (i_clk),
        .i_wr      (w_slot_wr),
        .i_rd_addr (w_slot_rd_addr),
        .o_rd_data (w_slot_q)
    );

    lzwe_dict_mem u_dict_mem (
        .i_clk     (i_clk),
        .i_wr      (w_dict_wr),
        .i_rd_addr (w_dict_rd_addr),
        .o_rd_data (w_dict_q)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_clearing  = (r_state == S_CLEAR);

    assign o_valid     = r_out_valid;
    assign o_code_word = r_out_code;
    assign o_last_code = r_out_last;

    // a slot is live only if its code belongs to this stream and points back at it
    assign w_entry_live = r_cand && (w_dict_q.slot == r_slot);
    assign w_key_match  = (w_dict_q.prefix == r_prefix) && (w_dict_q.data == r_byte);
    assign w_insert     = (r_state == S_CHECK) && !w_entry_live
                          && (r_next_free < lzwe_pkg::CODE_LIMIT);

    // hash read: first probe straight from the incoming byte, later ones step the slot
    always_comb begin
        if (r_state == S_IDLE) begin
            w_slot_rd_addr = lzwe_pkg::pair_hash(r_prefix, i_data_byte);
        end else begin
            w_slot_rd_addr = r_slot + lzwe_pkg::t_slot'(1);
        end
    end

    assign w_dict_rd_addr = w_slot_q;

    // clearing pass writes code 0, which is never a dictionary code
    always_comb begin
        w_slot_wr.en   = w_insert || w_clearing;
        w_slot_wr.addr = w_clearing ? r_clear_addr : r_slot;
        w_slot_wr.data = w_clearing ? '0 : r_next_free[lzwe_pkg::CODE_BITS-1:0];

        w_dict_wr.en          = w_insert;
        w_dict_wr.addr        = r_next_free[lzwe_pkg::CODE_BITS-1:0];
        w_dict_wr.data.prefix = r_prefix;
        w_dict_wr.data.data   = r_byte;
        w_dict_wr.data.slot   = r_slot;
    end

    always_comb begin
        n_state        = r_state;
        n_prefix       = r_prefix;
        n_prefix_valid = r_prefix_valid;
        n_next_free    = r_next_free;
        n_byte         = r_byte;
        n_eos          = r_eos;
        n_slot         = r_slot;
        n_code         = r_code;
        n_cand         = r_cand;
        n_clear_addr   = r_clear_addr;
        n_out_valid    = r_out_valid && !i_ready;
        n_out_code     = r_out_code;
        n_out_last     = r_out_last;

        case (r_state)
            S_CLEAR: begin
                n_clear_addr = r_clear_addr + lzwe_pkg::t_slot'(1);
                if (r_clear_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_byte = i_data_byte;
                    n_eos  = i_end_of_stream;
                    if (!r_prefix_valid) begin
                        // first byte of a stream just becomes the prefix
                        n_prefix       = lzwe_pkg::t_code'(i_data_byte);
                        n_prefix_valid = 1'b1;
                        if (i_end_of_stream) begin
                            n_state = S_EMIT_LAST;
                        end
                    end else begin
                        n_slot  = w_slot_rd_addr;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                n_code  = w_slot_q;
                n_cand  = ({1'b0, w_slot_q} >= lzwe_pkg::FIRST_CODE)
                          && ({1'b0, w_slot_q} < r_next_free);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_entry_live && w_key_match) begin
                    n_prefix = r_code;
                    n_state  = r_eos ? S_EMIT_LAST : S_IDLE;
                end else if (w_entry_live) begin
                    // occupied by another pair: next slot, read already issued
                    n_slot  = w_slot_rd_addr;
                    n_state = S_PROBE;
                end else begin
                    if (w_insert) begin
                        n_next_free = r_next_free + lzwe_pkg::FREE_BITS'(1);
                    end
                    n_state = S_EMIT_MISS;
                end
            end
            S_EMIT_MISS: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_prefix;
                    n_out_last  = 1'b0;
                    n_prefix    = lzwe_pkg::t_code'(r_byte);
                    n_state     = r_eos ? S_EMIT_LAST : S_IDLE;
                end
            end
            S_EMIT_LAST: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_code     = r_prefix;
                    n_out_last     = 1'b1;
                    n_prefix       = '0;
                    n_prefix_valid = 1'b0;
                    n_next_free    = lzwe_pkg::FIRST_CODE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clear_addr   <= '0;
            r_prefix       <= '0;
            r_prefix_valid <= 1'b0;
            r_next_free    <= lzwe_pkg::FIRST_CODE;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clear_addr   <= n_clear_addr;
            r_prefix       <= n_prefix;
            r_prefix_valid <= n_prefix_valid;
            r_next_free    <= n_next_free;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_eos      <= n_eos;
        r_slot     <= n_slot;
        r_code     <= n_code;
        r_cand     <= n_cand;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    // next free code stays within the dictionary range
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free >= lzwe_pkg::FIRST_CODE) && (r_next_free <= lzwe_pkg::CODE_LIMIT))
        else $error("next free code out of range");

    // an insert advances the free code by exactly one
    a_insert_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |=> (r_next_free == $past(r_next_free) + lzwe_pkg::FREE_BITS'(1)))
        else $error("dictionary insert did not advance free code");

    // a byte that extends a prefix always starts a probe
    a_probe_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_prefix_valid) |=> (r_state == S_PROBE))
        else $error("accepted byte did not start a probe");

    // the last code of a stream leaves the encoder ready for a fresh stream
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_LAST && w_out_free) |=>
        (!r_prefix_valid && o_valid && o_last_code && r_next_free == lzwe_pkg::FIRST_CODE))
        else $error("end of stream did not reset encoder state");

endmodule
